@@ src/aes_cbc_block_cipher_unit_defines.svh @@
// Assertion macros for the AES-CBC cipher unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef AES_CBC_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define AES_CBC_BLOCK_CIPHER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CBC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cbc: check failed");
`define CBC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cbc: check failed");
`else
`define CBC_ASSERT(label, clk, rst_n, prop)
`define CBC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ src/cbc_pkg.sv @@
// Shared types, register indexes and AES byte functions for the CBC cipher unit.
// No dependencies.
package cbc_pkg;

    localparam logic [2:0] CFG_KEY_SIZE   = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;
    localparam logic [2:0] CFG_IV_UPPER   = 3'd5;
    localparam logic [2:0] CFG_IV_LOWER   = 3'd6;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam int RK_ROWS = 15;

    typedef struct packed {
        logic       accept;
        logic       kexp_init;
        logic       kexp_step;
        logic [5:0] kidx;
        logic       load;
        logic       ark0;
        logic       round;
        logic       last;
        logic [3:0] rk_addr;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic       func;
        logic [3:0] nr;
    } t_sts;

    localparam logic [2047:0] SBOX_FWD = {
        256'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0,
        256'hb7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b275,
        256'h09832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
        256'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2,
        256'hcd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdb,
        256'he0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
        256'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9e,
        256'he1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] SBOX_INV = {
        256'h52096ad53036a538bf40a39e81f3d7fb7ce339829b2fff87348e4344c4dee9cb,
        256'h547b9432a6c2233dee4c950b42fac34e082ea16628d924b2765ba2496d8bd125,
        256'h72f8f66486689816d4a45ccc5d65b6926c704850fdedb9da5e154657a78d9d84,
        256'h90d8ab008cbcd30af7e45805b8b34506d02c1e8fca3f0f02c1afbd0301138a6b,
        256'h3a9111414f67dcea97f2cfcef0b4e67396ac7422e7ad3585e2f937e81c75df6e,
        256'h47f11a711d29c5896fb7620eaa18be1bfc563e4bc6d279209adbc0fe78cd5af4,
        256'h1fdda8338807c731b11210592780ec5f60517fa919b54a0d2de57a9f93c99cef,
        256'ha0e03b4dae2af5b0c8ebbb3c83539961172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_FWD[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return SBOX_INV[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // state byte n sits at bits [127-8n -: 8]
    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            r[8*i +: 8] = sbox(s[8*i +: 8]);
        end
        return r;
    endfunction

    function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            r[8*i +: 8] = inv_sbox(s[8*i +: 8]);
        end
        return r;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s);
        logic [127:0] r;
        for (int rr = 0; rr < 4; rr++) begin
            for (int c = 0; c < 4; c++) begin
                r[127 - 8*(rr + 4*c) -: 8] = s[127 - 8*(rr + 4*((c + rr) % 4)) -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
        logic [127:0] r;
        for (int rr = 0; rr < 4; rr++) begin
            for (int c = 0; c < 4; c++) begin
                r[127 - 8*(rr + 4*((c + rr) % 4)) -: 8] = s[127 - 8*(rr + 4*c) -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] a);
        logic [7:0] a0, a1, a2, a3;
        a0 = a[31:24]; a1 = a[23:16]; a2 = a[15:8]; a3 = a[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
        logic [7:0] x [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x2, x4, x8;
        for (int i = 0; i < 4; i++) begin
            x[i]  = a[31 - 8*i -: 8];
            x2    = xt(x[i]);
            x4    = xt(x2);
            x8    = xt(x4);
            m9[i] = x8 ^ x[i];
            mb[i] = x8 ^ x2 ^ x[i];
            md[i] = x8 ^ x4 ^ x[i];
            me[i] = x8 ^ x4 ^ x2;
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            r[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32]);
        end
        return r;
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            r[127 - 32*c -: 32] = inv_mix_col(s[127 - 32*c -: 32]);
        end
        return r;
    endfunction

endpackage

@@ src/aes_cbc_block_cipher_unit.sv @@
// Top level of the AES-CBC block cipher unit (128/192/256-bit keys).
// Depends on cbc_pkg, cbc_ctrl, cbc_dp (and cbc_ram below it).
//
// channel  | dir | handshake                     | payload
// ---------+-----+-------------------------------+-------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: block_upper, block_lower
//          |     |                               | tuser: func, start_chain
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: out_upper, out_lower
// cfg      | in  | i_cfg_we (no wait)            | i_cfg_addr, i_cfg_data
//
// Each item goes through the single round unit:
// accept, load, initial key add, one round per cycle, output load.
// After reset or any key/key-size write, the first item first expands the key
// into the round-key RAM, one 32-bit word per cycle (44, 52 or 60 words).
// Result sits in an output register; the next item is taken while it waits.
// Reset is synchronous active low and clears config, chain and control.
module aes_cbc_block_cipher_unit import cbc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] block_upper, [127:64] block_lower
    input  logic [1:0]   s_axis_tuser,   // [0] func, [1] start_chain
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [63:0] out_upper, [127:64] out_lower
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [63:0]  i_cfg_data
);
    t_cmd         cmd;
    t_sts         sts;
    logic [127:0] result;

    cbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // byte 0 of the block is the top byte of the 128-bit state
    cbc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_blk      ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .i_func     (s_axis_tuser[0]),
        .i_start    (s_axis_tuser[1]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (result)
    );

    assign m_axis_tdata = {result[63:0], result[127:64]};
endmodule

@@ src/cbc_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/cbc_dp.sv @@
// Datapath: config registers, key expansion, round-key RAM, AES round and chain.
// Depends on cbc_pkg and cbc_ram.
module cbc_dp import cbc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [63:0]  i_cfg_data,
    input  logic [127:0] i_blk,
    input  logic         i_func,
    input  logic         i_start,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    output logic [127:0] o_result
);
    logic [1:0]   r_key_size;
    logic [63:0]  r_key [4];
    logic [63:0]  r_iv_u, r_iv_l;
    logic [127:0] r_chain;
    logic [127:0] r_blk;
    logic         r_func;
    logic [127:0] r_st;
    logic [31:0]  r_win [8];
    logic [2:0]   r_kmod;
    logic [7:0]   r_rcon;
    logic [127:0] r_result;

    logic [3:0]   nk, nr;
    logic [2:0]   nk_m1;
    logic [255:0] key_all;
    logic [31:0]  w_far, t_word, w_new;
    logic [127:0] rk;
    logic [127:0] enc_sh, enc_nx, dec_ark, dec_nx;
    logic         ram_we;

    always_comb begin
        case (r_key_size)
            KEY_128: begin nk = 4'd4; nr = 4'd10; nk_m1 = 3'd3; w_far = r_win[3]; end
            KEY_192: begin nk = 4'd6; nr = 4'd12; nk_m1 = 3'd5; w_far = r_win[5]; end
            default: begin nk = 4'd8; nr = 4'd14; nk_m1 = 3'd7; w_far = r_win[7]; end
        endcase
    end

    assign key_all = {r_key[0], r_key[1], r_key[2], r_key[3]};

    always_comb begin
        t_word = r_win[0];
        if (r_kmod == 3'd0) begin
            t_word = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_kmod == 3'd4) begin
            t_word = sub_word(r_win[0]);
        end
        if (i_cmd.kidx < {2'b00, nk}) begin
            w_new = key_all[{~i_cmd.kidx[2:0], 5'b00000} +: 32];
        end else begin
            w_new = w_far ^ t_word;
        end
    end

    assign ram_we = i_cmd.kexp_step && (i_cmd.kidx[1:0] == 2'b11);

    cbc_ram #(.WIDTH(128), .DEPTH(RK_ROWS)) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.kidx[5:2]),
        .i_wdata ({r_win[2], r_win[1], r_win[0], w_new}),
        .i_raddr (i_cmd.rk_addr),
        .o_rdata (rk)
    );

    assign enc_sh  = shift_rows(sub_bytes(r_st));
    assign enc_nx  = (i_cmd.last ? enc_sh : mix_columns(enc_sh)) ^ rk;
    assign dec_ark = inv_sub_bytes(inv_shift_rows(r_st)) ^ rk;
    assign dec_nx  = i_cmd.last ? dec_ark : inv_mix_columns(dec_ark);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= '0;
            r_key[0]   <= '0;
            r_key[1]   <= '0;
            r_key[2]   <= '0;
            r_key[3]   <= '0;
            r_iv_u     <= '0;
            r_iv_l     <= '0;
            r_chain    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_KEY_SIZE:   r_key_size <= i_cfg_data[1:0];
                    CFG_KEY_WORD_0: r_key[0]   <= i_cfg_data;
                    CFG_KEY_WORD_1: r_key[1]   <= i_cfg_data;
                    CFG_KEY_WORD_2: r_key[2]   <= i_cfg_data;
                    CFG_KEY_WORD_3: r_key[3]   <= i_cfg_data;
                    CFG_IV_UPPER:   r_iv_u     <= i_cfg_data;
                    CFG_IV_LOWER:   r_iv_l     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept && i_start) begin
                r_chain <= {r_iv_u, r_iv_l};
            end else if (i_cmd.out_load) begin
                r_chain <= r_func ? r_blk : r_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_blk  <= i_blk;
            r_func <= i_func;
        end
        if (i_cmd.kexp_init) begin
            r_kmod <= 3'd0;
            r_rcon <= 8'h01;
        end else if (i_cmd.kexp_step) begin
            r_win[0] <= w_new;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_kmod <= (r_kmod == nk_m1) ? 3'd0 : r_kmod + 3'd1;
            if (r_kmod == 3'd0 && i_cmd.kidx >= {2'b00, nk}) begin
                r_rcon <= xt(r_rcon);
            end
        end
        if (i_cmd.load) begin
            r_st <= r_func ? r_blk : r_blk ^ r_chain;
        end else if (i_cmd.ark0) begin
            r_st <= r_st ^ rk;
        end else if (i_cmd.round) begin
            r_st <= r_func ? dec_nx : enc_nx;
        end
        if (i_cmd.out_load) begin
            r_result <= r_func ? r_st ^ r_chain : r_st;
        end
    end

    assign o_sts.func = r_func;
    assign o_sts.nr   = nr;
    assign o_result   = r_result;
endmodule

@@ src/cbc_ctrl.sv @@
// Controller: sequences key expansion, rounds and the output register.
// Depends on cbc_pkg and the assertion macro header.
`include "aes_cbc_block_cipher_unit_defines.svh"
module cbc_ctrl import cbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_KEXP, S_LOAD, S_ARK0, S_ROUND, S_DONE} t_state;

    t_state     r_state, n_state;
    logic       r_key_dirty;
    logic [5:0] r_kidx;
    logic [3:0] r_cnt, n_cnt;
    logic       r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.kidx = r_kidx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept    = 1'b1;
                    o_cmd.kexp_init = r_key_dirty;
                    n_state = r_key_dirty ? S_KEXP : S_LOAD;
                end
            end
            S_KEXP: begin
                o_cmd.kexp_step = 1'b1;
                if (r_kidx == {i_sts.nr, 2'b11}) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt   = 4'd0;
                n_state = S_ARK0;
            end
            S_ARK0: begin
                o_cmd.ark0 = 1'b1;
                n_cnt   = 4'd1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                o_cmd.last  = (r_cnt == i_sts.nr);
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == i_sts.nr) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // round key row for the round prepared next cycle
        o_cmd.rk_addr = i_sts.func ? i_sts.nr - n_cnt : n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_dirty <= 1'b1;
            r_kidx      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.accept) begin
                r_kidx <= '0;
            end else if (o_cmd.kexp_step) begin
                r_kidx <= r_kidx + 6'd1;
            end
            if (i_cfg_we && i_cfg_addr <= CFG_KEY_WORD_3) begin
                r_key_dirty <= 1'b1;
            end else if (o_cmd.kexp_step && n_state == S_LOAD) begin
                r_key_dirty <= 1'b0;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `CBC_ASSERT(a_key_ready_at_load, i_clk, i_rst_n, (r_state == S_LOAD) |-> !r_key_dirty)
    `CBC_ASSERT(a_round_in_range, i_clk, i_rst_n, (r_state == S_ROUND) |-> (r_cnt <= i_sts.nr))
    `CBC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, o_cmd.accept, (r_state == S_KEXP || r_state == S_LOAD))
    `CBC_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, o_cmd.out_load, r_out_valid)
endmodule

@@ tb/aes_cbc_block_cipher_unit_test.sv @@
// Testbench for the AES-CBC block cipher unit: random and directed blocks, checked
// against an in-bench AES/CBC predictor. Depends on cbc_pkg and the unit's RTL.
`timescale 1ns / 100ps

module aes_cbc_block_cipher_unit_test;
    import cbc_pkg::*;

    typedef struct {
        logic         func;
        logic         start;
        logic [63:0]  bu;
        logic [63:0]  bl;
    } blk_item_t;

    typedef struct {
        logic [63:0]  hi;
        logic [63:0]  lo;
    } blk_res_t;

    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // [63:0] block_upper, [127:64] block_lower
    logic [1:0]   s_axis_tuser = '0;   // [0] func, [1] start_chain
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // [63:0] out_upper, [127:64] out_lower
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [63:0]  i_cfg_data = '0;

    aes_cbc_block_cipher_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state: shadow registers, chain, round keys, S-boxes
    logic [1:0]   key_sz;
    logic [63:0]  key_w [4];
    logic [63:0]  iv_hi, iv_lo;
    logic [127:0] chain;
    logic [31:0]  rkey [60];
    logic [7:0]   fsb [256];
    logic [7:0]   isb [256];

    blk_item_t    pending_q [$];
    blk_res_t     cipher_q [$];
    int           mismatches = 0;
    int           sent = 0;
    logic         hold = 1'b0;
    int           idle_cnt = 0;

    function automatic logic [7:0] xtime(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = xtime(a);
        end
        return p;
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        return {fsb[w[31:24]], fsb[w[23:16]], fsb[w[15:8]], fsb[w[7:0]]};
    endfunction

    // expands the key into rkey, returns round count; size code 3 acts as 256-bit
    function automatic int expand_round_keys();
        int nk, total;
        logic [31:0] t;
        logic [7:0] rc;
        nk = (key_sz == KEY_128) ? 4 : (key_sz == KEY_192) ? 6 : 8;
        total = 4 * (nk + 7);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            rkey[i] = i[0] ? key_w[i >> 1][31:0] : key_w[i >> 1][63:32];
        for (int i = nk; i < total; i++) begin
            t = rkey[i-1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = xtime(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            rkey[i] = rkey[i-nk] ^ t;
        end
        return nk + 6;
    endfunction

    // byte n of the state sits at [127-8n -: 8]
    function automatic logic [127:0] add_key(logic [127:0] s, int r);
        for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= rkey[4*r + c];
        return s;
    endfunction

    function automatic logic [127:0] subst(logic [127:0] s, bit inv);
        for (int i = 0; i < 16; i++)
            s[8*i +: 8] = inv ? isb[s[8*i +: 8]] : fsb[s[8*i +: 8]];
        return s;
    endfunction

    function automatic logic [127:0] rows(logic [127:0] s, bit inv);
        logic [127:0] o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inv) o[127-8*(r+4*((c+r)&3)) -: 8] = s[127-8*(r+4*c) -: 8];
                else     o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
        return o;
    endfunction

    function automatic logic [127:0] mix(logic [127:0] s, bit inv);
        logic [7:0] a [4];
        logic [7:0] m [4];
        logic [127:0] o;
        if (inv) begin
            m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
        end else begin
            m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
        end
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) a[j] = s[127-8*(4*c+j) -: 8];
            for (int j = 0; j < 4; j++)
                o[127-8*(4*c+j) -: 8] = gf_mul(a[j], m[0]) ^ gf_mul(a[(j+1)&3], m[1])
                                      ^ gf_mul(a[(j+2)&3], m[2]) ^ gf_mul(a[(j+3)&3], m[3]);
        end
        return o;
    endfunction

    function automatic blk_res_t cbc_step(blk_item_t it);
        int nr;
        logic [127:0] s;
        blk_res_t res;
        nr = expand_round_keys();
        if (it.start) chain = {iv_hi, iv_lo};
        s = {it.bu, it.bl};
        if (!it.func) begin
            s = add_key(s ^ chain, 0);
            for (int r = 1; r <= nr; r++) begin
                s = rows(subst(s, 0), 0);
                if (r != nr) s = mix(s, 0);
                s = add_key(s, r);
            end
            chain = s;
        end else begin
            s = add_key(s, nr);
            for (int r = nr - 1; r >= 0; r--) begin
                s = add_key(subst(rows(s, 1), 1), r);
                if (r != 0) s = mix(s, 1);
            end
            s ^= chain;
            chain = {it.bu, it.bl};
        end
        res.hi = s[127:64];
        res.lo = s[63:0];
        return res;
    endfunction

    // driver: one item per handshake, random gaps except in a quiet stretch
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            cipher_q.push_back(cbc_step('{s_axis_tuser[0], s_axis_tuser[1],
                                          s_axis_tdata[63:0], s_axis_tdata[127:64]}));
            sent <= sent + 1;
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_q.size() != 0 && !hold && i_rst_n &&
                ((sent > 400 && sent < 650) || $urandom_range(0, 99) >= 33)) begin
                blk_item_t it;
                it = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {it.bl, it.bu};
                s_axis_tuser  <= {it.start, it.func};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest predicted block
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (cipher_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                blk_res_t e;
                e = cipher_q.pop_front();
                if (m_axis_tdata[63:0] !== e.hi || m_axis_tdata[127:64] !== e.lo) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hi %h lo %h, got hi %h lo %h",
                                 e.hi, e.lo, m_axis_tdata[63:0], m_axis_tdata[127:64]);
                end
            end
        end
        m_axis_tready <= i_rst_n &&
                         ((sent > 400 && sent < 650) || $urandom_range(0, 99) >= 33);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_KEY_SIZE:   key_sz = val[1:0];
            CFG_KEY_WORD_0: key_w[0] = val;
            CFG_KEY_WORD_1: key_w[1] = val;
            CFG_KEY_WORD_2: key_w[2] = val;
            CFG_KEY_WORD_3: key_w[3] = val;
            CFG_IV_UPPER:   iv_hi = val;
            CFG_IV_LOWER:   iv_lo = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_setup(logic [1:0] ks, logic [63:0] k0, logic [63:0] k1,
                              logic [63:0] k2, logic [63:0] k3,
                              logic [63:0] ivh, logic [63:0] ivl);
        cfg_write(CFG_KEY_SIZE, {62'd0, ks});
        cfg_write(CFG_KEY_WORD_0, k0);
        cfg_write(CFG_KEY_WORD_1, k1);
        cfg_write(CFG_KEY_WORD_2, k2);
        cfg_write(CFG_KEY_WORD_3, k3);
        cfg_write(CFG_IV_UPPER, ivh);
        cfg_write(CFG_IV_LOWER, ivl);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || cipher_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // mostly chains: a start block then a run, mixed encrypt and decrypt
    task automatic push_random(int n);
        blk_item_t it;
        for (int i = 0; i < n; i++) begin
            it.start = ($urandom_range(0, 7) == 0);
            it.func  = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0: begin it.bu = '0; it.bl = '1; end
                1: begin it.bu = '1; it.bl = '0; end
                default: begin it.bu = rnd64(); it.bl = rnd64(); end
            endcase
            pending_q.push_back(it);
        end
    endtask

    initial begin
        for (int x = 0; x < 256; x++) begin
            logic [7:0] inv, b;
            inv = 8'h00;
            if (x != 0) begin
                inv = 8'h01;
                for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
            end
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fsb[x] = b;
            isb[b] = x[7:0];
        end
        key_sz = KEY_128;
        key_w = '{default: '0};
        iv_hi = '0;
        iv_lo = '0;
        chain = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero defaults: chain from reset, no start flag
        pending_q.push_back('{1'b0, 1'b0, 64'h0, 64'h0});
        pending_q.push_back('{1'b1, 1'b0, '1, '1});
        drain();

        // FIPS-style 128-bit key, directed block corners
        load_setup(KEY_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0,
                   64'h0011223344556677, 64'h8899aabbccddeeff);
        pending_q.push_back('{1'b0, 1'b1, 64'h0, 64'h0});
        pending_q.push_back('{1'b0, 1'b0, '1, '1});
        pending_q.push_back('{1'b0, 1'b0, 64'h8000000000000000, 64'h1});
        pending_q.push_back('{1'b1, 1'b1, 64'h0, 64'h0});
        pending_q.push_back('{1'b1, 1'b0, '1, '1});
        pending_q.push_back('{1'b1, 1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210});
        pending_q.push_back('{1'b0, 1'b1, '1, 64'h0});
        pending_q.push_back('{1'b1, 1'b1, 64'h0, '1});
        push_random(190);
        repeat (300) @(posedge i_clk);
        // sender holds off until every block sent so far has come back
        hold = 1'b1;
        do @(posedge i_clk);
        while (s_axis_tvalid || cipher_q.size() != 0);
        hold = 1'b0;
        drain();
        push_random(200);
        drain();

        load_setup(KEY_192, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
        pending_q.push_back('{1'b0, 1'b1, '1, '1});
        pending_q.push_back('{1'b1, 1'b0, 64'h0, 64'h0});
        push_random(240);
        drain();

        load_setup(2'd2, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
        pending_q.push_back('{1'b0, 1'b1, 64'h0, 64'h0});
        pending_q.push_back('{1'b1, 1'b1, '1, '1});
        push_random(240);
        drain();

        // unused size code behaves as a 256-bit key; all-ones key and IV
        load_setup(2'd3, '1, '1, '1, '1, '1, '1);
        pending_q.push_back('{1'b0, 1'b1, 64'h0, 64'h0});
        pending_q.push_back('{1'b1, 1'b1, 64'h0, 64'h0});
        push_random(220);
        drain();

        // back to 128 bits with an all-zero key, then a fresh random key
        load_setup(KEY_128, '0, '0, rnd64(), rnd64(), '0, '0);
        push_random(120);
        drain();
        load_setup(KEY_128, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
        push_random(120);
        drain();

        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && cipher_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
